@@ rtl/core/frlm_pkg.sv @@
// Shared types and constants of the flash ring log manager.
`default_nettype none

package frlm_pkg;

   localparam logic [1:0] MODE_SCAN  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] write_data;
      logic [9:0] read_offset;
   } frlm_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       block_done;
      logic [1:0] current_sector;
      logic [2:0] current_block;
      logic [1:0] spare_sector;
   } frlm_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_SECT,
      ST_SCAN_BLK_RD,
      ST_SCAN_BLK_CHK,
      ST_ERASE,
      ST_WR_RD,
      ST_WR_MERGE,
      ST_RD_ADDR,
      ST_RD_DATA
   } frlm_state_type;

endpackage

`default_nettype wire

@@ rtl/core/frlm_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module frlm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/core/flash_ring_log_manager_core.sv @@
// Top level of the flash ring log manager: sequencer around one flash store RAM.
`default_nettype none

// The whole log state lives in one byte-wide RAM of SECTOR_COUNT * SECTOR_BYTES
// entries with a registered read, so every request is worked through that single
// RAM. After reset the block sweeps the RAM to 0xFF, one byte per cycle, and
// holds busy high meanwhile. A write request reads the byte, then does a merged
// write-back; the first byte of a block that lands on a full sector first erases
// the next spare. A read request does a memory read, then responds; the offset is
// reduced with a quotient that is taken as the request is accepted. A scan streams
// through the sectors at one byte per cycle until it finds an erased one, then
// probes block heads, reading each head and then checking it. An unused mode is
// answered without leaving idle. Each request yields exactly one response, shown
// on rsp_payload for the single cycle in which rsp_valid is high; the receiver
// must take it then.
module flash_ring_log_manager_core
   import frlm_pkg::*;
#(
   parameter int SECTOR_COUNT = 4,
   parameter int SECTOR_BYTES = 4096,
   parameter int BLOCK_BYTES  = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire frlm_req_type req_payload,
   output logic              rsp_valid,
   output frlm_rsp_type      rsp_payload
);

   localparam int BPS     = SECTOR_BYTES / BLOCK_BYTES;
   localparam int BLK_MAX = (BPS > 0) ? BPS : 1;
   localparam int STORE   = SECTOR_COUNT * SECTOR_BYTES;
   localparam int AW      = $clog2(STORE);
   localparam int SW      = $clog2(SECTOR_COUNT);
   localparam int BLW     = $clog2(BLK_MAX + 1);
   localparam int PW      = $clog2(BLOCK_BYTES);
   localparam int CW      = $clog2(STORE + 1);
   localparam int RSHIFT  = 20;
   localparam int RECIP   = ((1 << RSHIFT) + BLOCK_BYTES - 1) / BLOCK_BYTES;

   frlm_state_type state_ff, state_in;

   logic [SW-1:0]  sec_ff, sec_in;
   logic [BLW-1:0] blk_ff, blk_in;
   logic [SW-1:0]  spare_ff, spare_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [SW-1:0]  scn_sec_ff, scn_sec_in;
   logic           chk_vld_ff, chk_vld_in;
   logic           chk_last_ff, chk_last_in;
   frlm_req_type   req_ff, req_in;
   logic [9:0]     q_ff, q_in;
   logic [AW-1:0]  wr_addr_ff, wr_addr_in;
   logic           inrange_ff, inrange_in;
   logic           rsp_valid_ff, rsp_valid_in;
   frlm_rsp_type   rsp_ff, rsp_in;

   logic           ram_we;
   logic [AW-1:0]  ram_waddr;
   logic [7:0]     ram_wdata;
   logic [AW-1:0]  ram_raddr;
   logic [7:0]     ram_rdata;

   logic           accept;
   logic           need_move;
   logic           sect_bad;
   logic           sect_good;
   logic           scan_last_sec;
   logic [SW-1:0]  rd_prev_sec;
   logic [SW-1:0]  scn_prev_sec;
   logic [SW-1:0]  spare_next;
   logic [SW-1:0]  rd_sec;
   logic [31:0]    rd_blk32;
   logic [31:0]    off32;
   logic [31:0]    wr_addr32;
   logic [31:0]    rd_addr32;
   logic [31:0]    scan_addr32;
   logic [31:0]    head_addr32;
   logic [31:0]    erase_addr32;
   logic [31:0]    q_prod32;
   logic [31:0]    sec_n32;
   logic [31:0]    blk_n32;
   logic [31:0]    spare_n32;
   logic           respond;
   logic [7:0]     rd_byte;
   logic           done;

   frlm_ram #(
      .WIDTH (8),
      .DEPTH (STORE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign need_move = (pos_ff == '0) && (32'(blk_ff) >= 32'(BPS));

   assign sect_bad      = chk_vld_ff && (ram_rdata != ERASED_BYTE);
   assign sect_good     = chk_vld_ff && chk_last_ff && !sect_bad;
   assign scan_last_sec = (scn_sec_ff == SW'(SECTOR_COUNT - 1));

   assign rd_prev_sec  = (sec_ff == '0) ? SW'(SECTOR_COUNT - 1) : sec_ff - SW'(1);
   assign scn_prev_sec = (scn_sec_ff == '0) ? SW'(SECTOR_COUNT - 1) : scn_sec_ff - SW'(1);
   assign spare_next   = (spare_ff == SW'(SECTOR_COUNT - 1)) ? '0 : spare_ff + SW'(1);

   // The newest block is the one before the current one, wrapping into the
   // previous sector; address arithmetic wraps at 32 bits on purpose.
   assign rd_sec   = (blk_ff == '0) ? rd_prev_sec : sec_ff;
   assign rd_blk32 = (blk_ff == '0) ? 32'(BPS) - 32'd1 : 32'(blk_ff) - 32'd1;
   assign off32    = 32'(req_ff.read_offset) - 32'(q_ff) * 32'(BLOCK_BYTES);

   assign wr_addr32 = 32'(sec_ff) * 32'(SECTOR_BYTES) + 32'(blk_ff) * 32'(BLOCK_BYTES)
                      + 32'(pos_ff);
   assign rd_addr32 = 32'(rd_sec) * 32'(SECTOR_BYTES) + rd_blk32 * 32'(BLOCK_BYTES)
                      + off32;
   assign scan_addr32  = 32'(scn_sec_ff) * 32'(SECTOR_BYTES) + 32'(cnt_ff);
   assign head_addr32  = 32'(sec_ff) * 32'(SECTOR_BYTES) + 32'(cnt_ff) * 32'(BLOCK_BYTES);
   assign erase_addr32 = 32'(spare_ff) * 32'(SECTOR_BYTES) + 32'(cnt_ff);
   assign q_prod32     = 32'(req_payload.read_offset) * 32'(RECIP);

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CW'(STORE - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.mode)
                  MODE_SCAN:  state_in = ST_SCAN_SECT;
                  MODE_WRITE: state_in = need_move ? ST_ERASE : ST_WR_RD;
                  MODE_READ:  state_in = ST_RD_ADDR;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN_SECT: begin
            if (sect_bad && scan_last_sec) state_in = ST_IDLE;
            else if (sect_good)            state_in = ST_SCAN_BLK_RD;
         end
         ST_SCAN_BLK_RD: begin
            state_in = (cnt_ff == CW'(BPS)) ? ST_IDLE : ST_SCAN_BLK_CHK;
         end
         ST_SCAN_BLK_CHK: begin
            state_in = (ram_rdata == ERASED_BYTE) ? ST_IDLE : ST_SCAN_BLK_RD;
         end
         ST_ERASE: begin
            if (cnt_ff == CW'(SECTOR_BYTES - 1)) state_in = ST_WR_RD;
         end
         ST_WR_RD:    state_in = ST_WR_MERGE;
         ST_WR_MERGE: state_in = ST_IDLE;
         ST_RD_ADDR:  state_in = ST_RD_DATA;
         ST_RD_DATA:  state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin : datapath
      ram_we      = 1'b0;
      ram_waddr   = wr_addr_ff;
      ram_wdata   = ERASED_BYTE;
      ram_raddr   = '0;
      sec_in      = sec_ff;
      blk_in      = blk_ff;
      spare_in    = spare_ff;
      pos_in      = pos_ff;
      cnt_in      = cnt_ff;
      scn_sec_in  = scn_sec_ff;
      chk_vld_in  = 1'b0;
      chk_last_in = 1'b0;
      req_in      = req_ff;
      q_in        = q_ff;
      wr_addr_in  = wr_addr_ff;
      inrange_in  = inrange_ff;
      respond     = 1'b0;
      rd_byte     = '0;
      done        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[AW-1:0];
            cnt_in    = (cnt_ff == CW'(STORE - 1)) ? '0 : cnt_ff + CW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               req_in = req_payload;
               q_in   = 10'(q_prod32 >> RSHIFT);
               cnt_in = '0;
               unique case (req_payload.mode)
                  MODE_SCAN: begin
                     pos_in     = '0;
                     scn_sec_in = '0;
                  end
                  MODE_WRITE: begin
                     // A full sector hands over to the spare; the sector after
                     // it is erased before the byte goes in.
                     if (need_move) begin
                        sec_in   = spare_ff;
                        blk_in   = '0;
                        spare_in = spare_next;
                     end
                  end
                  MODE_READ: begin
                  end
                  default: begin
                     respond = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN_SECT: begin
            if (sect_bad) begin
               if (scan_last_sec) begin
                  spare_in = '0;
                  sec_in   = SW'(SECTOR_COUNT - 1);
                  blk_in   = BLW'(BPS);
                  respond  = 1'b1;
               end else begin
                  scn_sec_in = scn_sec_ff + SW'(1);
                  cnt_in     = '0;
               end
            end else if (sect_good) begin
               spare_in = scn_sec_ff;
               sec_in   = scn_prev_sec;
               cnt_in   = '0;
            end else if (cnt_ff < CW'(SECTOR_BYTES)) begin
               ram_raddr   = scan_addr32[AW-1:0];
               cnt_in      = cnt_ff + CW'(1);
               chk_vld_in  = 1'b1;
               chk_last_in = (cnt_ff == CW'(SECTOR_BYTES - 1));
            end
         end
         ST_SCAN_BLK_RD: begin
            if (cnt_ff == CW'(BPS)) begin
               blk_in  = BLW'(BPS);
               respond = 1'b1;
            end else begin
               ram_raddr = head_addr32[AW-1:0];
            end
         end
         ST_SCAN_BLK_CHK: begin
            if (ram_rdata == ERASED_BYTE) begin
               blk_in  = BLW'(cnt_ff);
               respond = 1'b1;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         ST_ERASE: begin
            ram_we    = 1'b1;
            ram_waddr = erase_addr32[AW-1:0];
            cnt_in    = cnt_ff + CW'(1);
         end
         ST_WR_RD: begin
            ram_raddr  = wr_addr32[AW-1:0];
            wr_addr_in = wr_addr32[AW-1:0];
            inrange_in = (wr_addr32 < 32'(STORE));
         end
         ST_WR_MERGE: begin
            ram_we    = inrange_ff;
            ram_waddr = wr_addr_ff;
            ram_wdata = ram_rdata & req_ff.write_data;
            respond   = 1'b1;
            if (pos_ff == PW'(BLOCK_BYTES - 1)) begin
               pos_in = '0;
               blk_in = blk_ff + BLW'(1);
               done   = 1'b1;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end
         ST_RD_ADDR: begin
            ram_raddr  = rd_addr32[AW-1:0];
            inrange_in = (rd_addr32 < 32'(STORE));
         end
         ST_RD_DATA: begin
            rd_byte = inrange_ff ? ram_rdata : ERASED_BYTE;
            respond = 1'b1;
         end
         default: begin
         end
      endcase

      sec_n32   = 32'(sec_in);
      blk_n32   = 32'(blk_in);
      spare_n32 = 32'(spare_in);

      rsp_valid_in          = respond;
      rsp_in                = rsp_ff;
      rsp_in.read_data      = rd_byte;
      rsp_in.block_done     = done;
      rsp_in.current_sector = sec_n32[1:0];
      rsp_in.current_block  = blk_n32[2:0];
      rsp_in.spare_sector   = spare_n32[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sec_ff       <= '0;
         blk_ff       <= '0;
         spare_ff     <= '0;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         scn_sec_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         chk_last_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         blk_ff       <= blk_in;
         spare_ff     <= spare_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         scn_sec_ff   <= scn_sec_in;
         chk_vld_ff   <= chk_vld_in;
         chk_last_ff  <= chk_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      q_ff       <= q_in;
      wr_addr_ff <= wr_addr_in;
      inrange_ff <= inrange_in;
      rsp_ff     <= rsp_in;
   end

   // The clearing pass must run before any request is taken.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   a_pointers_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(sec_ff) < 32'(SECTOR_COUNT)) && (32'(spare_ff) < 32'(SECTOR_COUNT))
      && (32'(blk_ff) <= 32'(BLK_MAX)))
      else $error("log pointer out of range");

   a_partial_block: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) |-> (32'(blk_ff) < 32'(BLK_MAX)))
      else $error("partly written block on a full sector");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !ram_we)
      else $error("store written while idle");

   a_no_rsp_from_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !rsp_valid)
      else $error("response during the clearing pass");

endmodule

`default_nettype wire

@@ bench/flash_ring_log_manager_core_test.sv @@
// Self-checking testbench of the flash ring log manager core.
`default_nettype none

module flash_ring_log_manager_core_test;
   import frlm_pkg::*;

   localparam int SECTOR_COUNT      = 4;
   localparam int SECTOR_BYTES      = 4096;
   localparam int BLOCK_BYTES       = 1024;
   localparam int BLOCKS_PER_SECTOR = SECTOR_BYTES / BLOCK_BYTES;
   localparam int STORE_BYTES       = SECTOR_COUNT * SECTOR_BYTES;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1000;
   // Sized to outlast clearing after reset, a full scan and a sector erase.
   localparam int IDLE_LIMIT = 200000;

   // Mirrors the flash contents and the log pointers, and queues the response
   // that each accepted request should produce.
   class flash_log_predictor;
      logic [7:0] store [STORE_BYTES];
      logic [1:0] sector_ptr;
      logic [2:0] block_ptr;
      logic [1:0] spare_ptr;
      logic [9:0] byte_pos;
      frlm_rsp_type expected_responses[$];
      int failures;

      function new();
         foreach (store[i]) store[i] = ERASED_BYTE;
         sector_ptr = '0;
         block_ptr  = '0;
         spare_ptr  = '0;
         byte_pos   = '0;
         failures   = 0;
      endfunction

      function int byte_address(int sec, int blk, int pos);
         return sec * SECTOR_BYTES + blk * BLOCK_BYTES + pos;
      endfunction

      function bit sector_is_erased(int sec);
         for (int i = 0; i < SECTOR_BYTES; i++) begin
            if (store[sec * SECTOR_BYTES + i] != ERASED_BYTE) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void rescan();
         int found;
         found = -1;
         byte_pos = '0;
         for (int s = 0; s < SECTOR_COUNT && found < 0; s++) begin
            if (sector_is_erased(s)) found = s;
         end
         if (found < 0) begin
            spare_ptr  = '0;
            sector_ptr = 2'(SECTOR_COUNT - 1);
            block_ptr  = 3'(BLOCKS_PER_SECTOR);
            return;
         end
         spare_ptr  = 2'(found);
         sector_ptr = 2'((found + SECTOR_COUNT - 1) % SECTOR_COUNT);
         block_ptr  = 3'(BLOCKS_PER_SECTOR);
         // Walking downward leaves the lowest block with an erased head.
         for (int b = BLOCKS_PER_SECTOR - 1; b >= 0; b--) begin
            if (store[byte_address(sector_ptr, b, 0)] == ERASED_BYTE) block_ptr = 3'(b);
         end
      endfunction

      function bit append_byte(logic [7:0] data);
         int addr;
         if (byte_pos == 0 && block_ptr >= BLOCKS_PER_SECTOR) begin
            sector_ptr = spare_ptr;
            block_ptr  = '0;
            spare_ptr  = 2'((sector_ptr + 1) % SECTOR_COUNT);
            for (int i = 0; i < SECTOR_BYTES; i++) store[spare_ptr * SECTOR_BYTES + i] = ERASED_BYTE;
         end
         addr = byte_address(sector_ptr, block_ptr, byte_pos);
         store[addr] = store[addr] & data;
         if (byte_pos == BLOCK_BYTES - 1) begin
            byte_pos = '0;
            block_ptr++;
            return 1'b1;
         end
         byte_pos++;
         return 1'b0;
      endfunction

      function logic [7:0] newest_block_byte(logic [9:0] offset);
         int sec;
         int blk;
         sec = sector_ptr;
         if (block_ptr == 0) begin
            sec = (sec + SECTOR_COUNT - 1) % SECTOR_COUNT;
            blk = BLOCKS_PER_SECTOR - 1;
         end else begin
            blk = block_ptr - 1;
         end
         return store[byte_address(sec, blk, offset % BLOCK_BYTES)];
      endfunction

      function void note_request(frlm_req_type req);
         frlm_rsp_type rsp;
         rsp = '0;
         case (req.mode)
            MODE_SCAN: begin
               rescan();
            end
            MODE_WRITE: begin
               rsp.block_done = append_byte(req.write_data);
            end
            MODE_READ: begin
               rsp.read_data = newest_block_byte(req.read_offset);
            end
            default: begin
            end
         endcase
         rsp.current_sector = sector_ptr;
         rsp.current_block  = block_ptr;
         rsp.spare_sector   = spare_ptr;
         expected_responses.push_back(rsp);
      endfunction

      function void report_field(string field, int unsigned want, int unsigned seen);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
         failures++;
      endfunction

      function void check_response(frlm_rsp_type got);
         frlm_rsp_type want;
         if (expected_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            failures++;
            return;
         end
         want = expected_responses.pop_front();
         if (got.read_data !== want.read_data)
            report_field("read_data", want.read_data, got.read_data);
         if (got.block_done !== want.block_done)
            report_field("block_done", want.block_done, got.block_done);
         if (got.current_sector !== want.current_sector)
            report_field("current_sector", want.current_sector, got.current_sector);
         if (got.current_block !== want.current_block)
            report_field("current_block", want.current_block, got.current_block);
         if (got.spare_sector !== want.spare_sector)
            report_field("spare_sector", want.spare_sector, got.spare_sector);
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   frlm_req_type req_payload = '0;
   logic         rsp_valid;
   frlm_rsp_type rsp_payload;

   flash_log_predictor ring_log = new();
   int items_sent = 0;
   bit steady = 1'b0;
   bit had_full_block = 1'b0;

   flash_ring_log_manager_core #(
      .SECTOR_COUNT(SECTOR_COUNT),
      .SECTOR_BYTES(SECTOR_BYTES),
      .BLOCK_BYTES (BLOCK_BYTES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) ring_log.check_response(rsp_payload);
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("[flash_ring_log_manager_core] ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Presents one request and returns at the edge that accepts it, or after the
   // idle gap that follows it.
   task automatic issue(logic [1:0] mode, logic [7:0] data, logic [9:0] offset);
      frlm_req_type req;
      int gap;
      req.mode        = mode;
      req.write_data  = data;
      req.read_offset = offset;
      start       <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (busy);
      ring_log.note_request(req);
      if (mode != MODE_UNUSED) items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [9:0] random_offset();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return 10'h000;
      if (r == 1) return 10'h3FF;
      return 10'($urandom_range(0, 1023));
   endfunction

   // A scan first when a block is half written, so the next write lands on a block head.
   task automatic align_to_block();
      if (ring_log.byte_pos != 0) issue(MODE_SCAN, 8'($urandom), random_offset());
   endtask

   initial begin : stimulus
      int pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Fresh store: the newest block wraps back to the last block of the last sector.
      issue(MODE_READ, 8'h00, 10'h000);
      issue(MODE_READ, 8'hFF, 10'h3FF);
      issue(MODE_UNUSED, 8'hFF, 10'h3FF);
      // Sector 0 is both current and spare after reset.
      issue(MODE_WRITE, 8'h00, 10'h3FF);
      issue(MODE_WRITE, 8'hFF, 10'h000);
      issue(MODE_WRITE, 8'hA5, 10'h155);
      issue(MODE_SCAN, 8'h00, 10'h000);
      issue(MODE_READ, 8'h00, 10'h000);
      issue(MODE_READ, 8'h00, 10'h002);
      issue(MODE_READ, 8'h00, 10'h3FF);
      issue(MODE_UNUSED, 8'h00, 10'h000);
      // Abandon the remaining blocks so the sector reads as full.
      for (int k = 0; k < 3; k++) begin
         issue(MODE_WRITE, 8'h7F >> k, 10'h000);
         issue(MODE_SCAN, 8'h00, 10'h000);
      end
      issue(MODE_READ, 8'h00, 10'h000);
      // Full sector: this write moves to the spare and erases the next sector.
      issue(MODE_WRITE, 8'h3C, 10'h000);
      issue(MODE_READ, 8'h00, 10'h000);
      issue(MODE_SCAN, 8'h00, 10'h000);
      issue(MODE_READ, 8'h00, 10'h001);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         if (!had_full_block && items_sent >= RANDOM_ITEMS / 2) pick = 99;
         if (pick < 42) begin
            // Write the head of a block with a cleared bit, then abandon it by a scan.
            align_to_block();
            issue(MODE_WRITE, 8'($urandom_range(0, 254)), random_offset());
            repeat ($urandom_range(0, 3)) issue(MODE_WRITE, 8'($urandom), random_offset());
            issue(MODE_SCAN, 8'($urandom), random_offset());
         end else if (pick < 70) begin
            repeat ($urandom_range(1, 12)) issue(MODE_READ, 8'($urandom), random_offset());
         end else if (pick < 84) begin
            repeat ($urandom_range(1, 40)) issue(MODE_WRITE, 8'($urandom), random_offset());
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 4))
               issue(2'($urandom_range(0, 3)), 8'($urandom), 10'($urandom));
         end else begin
            align_to_block();
            repeat (BLOCK_BYTES) issue(MODE_WRITE, 8'($urandom), random_offset());
            had_full_block = 1'b1;
            repeat ($urandom_range(1, 4)) issue(MODE_READ, 8'($urandom), random_offset());
         end
      end
      steady = 1'b0;
      start <= 1'b0;

      while (ring_log.expected_responses.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (ring_log.failures == 0 && ring_log.expected_responses.size() == 0)
         $display("[flash_ring_log_manager_core] OK");
      else
         $display("[flash_ring_log_manager_core] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/frlm_pkg.sv
rtl/core/frlm_ram.sv
rtl/core/flash_ring_log_manager_core.sv
bench/flash_ring_log_manager_core_test.sv
